FILE: src/tsig_pkg.sv
package tsig_pkg;

   // Number of models with their own counter and last instant. It must stay a power
   // of two, because the model field is folded onto the table index by its low bits.
   localparam int MODEL_COUNT = 64;
   localparam int MODEL_W     = $clog2(MODEL_COUNT);

   localparam int MODEL_FIELD_W = 6;
   localparam int NOW_W         = 47;
   localparam int EPOCH_W       = 37;
   localparam int SEQ_W         = 18;
   localparam int INST_W        = 48;
   localparam int CHAR_W        = 8;
   localparam int DIGIT_W       = 6;
   localparam int PREFIX_W      = 40;
   localparam int TIME_CHARS    = 7;
   localparam int TIME_W        = TIME_CHARS * CHAR_W;
   localparam int ENTRY_W       = INST_W + SEQ_W;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 96;

   localparam logic [SEQ_W-1:0] RESET_SEQUENCE = SEQ_W'(1024);
   localparam logic [SEQ_W-1:0] RESET_MAX_SEQ  = SEQ_W'(262143);

   typedef enum logic [1:0] {
      CSR_EPOCH_SECONDS  = 2'd0,
      CSR_EPOCH_VALID    = 2'd1,
      CSR_START_SEQUENCE = 2'd2,
      CSR_MAX_SEQUENCE   = 2'd3
   } csr_index_type;

   typedef enum logic {
      CMD_GENERATE = 1'b0,
      CMD_RESET    = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_EPOCH_UNSET = 3'd1,
      STATUS_EPOCH_BAD   = 3'd2,
      STATUS_OVERFLOW    = 3'd3,
      STATUS_NEED_RESET  = 3'd4,
      STATUS_RESET_DONE  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_READ = 2'd1,
      ST_EXEC = 2'd2
   } state_type;

   // Maps a 6-bit digit onto the symbol set 0-9, A-Z, a-z, '.', '-'.
   function automatic logic [CHAR_W-1:0] sym(input logic [DIGIT_W-1:0] v);
      logic [CHAR_W-1:0] c;
      if (v < 6'd10) begin
         c = 8'h30 + {2'b00, v};
      end else if (v < 6'd36) begin
         c = 8'h41 + {2'b00, v} - 8'd10;
      end else if (v < 6'd62) begin
         c = 8'h61 + {2'b00, v} - 8'd36;
      end else if (v == 6'd62) begin
         c = 8'h2E;
      end else begin
         c = 8'h2D;
      end
      return c;
   endfunction

endpackage

FILE: src/time_sequence_id_generator.sv
// Time and sequence identifier generator. Every model (0 to 63) owns an 18-bit
// sequence counter and the 48-bit signed instant of its last identifier; both live
// in one 64-entry synchronous memory, with a valid flag per entry that makes an
// untouched entry read as counter 1024 and instant 0 right after reset, so no
// clearing pass is needed. A generate transfer (req_tuser = 0) computes
// instant = now_ms - epoch_seconds * 1000 and, when the epoch is set and the counter
// is below max_sequence, returns a twelve-character identifier and advances the
// counter; an exhausted counter returns one of three errors from a signed compare
// of the stored instant with the new one. A reset transfer (req_tuser = 1) reloads
// the counter from start_sequence. Every request gives exactly one response.
// A request passes through the sequencer states in order: the accept cycle issues
// the memory read, the next cycle waits out the read latency while the instant is
// formed, and the execute step does the read-modify-write and loads the response
// register. A new request is accepted while an earlier response still waits in
// that register, but only after the last request has left the execute step.
// Configuration registers are written with csr_we, csr_index and csr_wdata; the
// user must write them only while no request is in flight; the block does not check.
module time_sequence_id_generator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Fields from bit 0: model (6), now_ms (47), three zero pad bits.
   input  logic [tsig_pkg::REQ_DATA_W-1:0]    req_tdata,
   // Fields from bit 0: command (1).
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Fields from bit 0: id_prefix_chars (40), id_time_chars (56).
   output logic [tsig_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // Fields from bit 0: status (3).
   output logic [2:0]                         rsp_tuser,
   input  logic                               csr_we,
   input  logic [1:0]                         csr_index,
   input  logic [tsig_pkg::EPOCH_W-1:0]       csr_wdata
);
   import tsig_pkg::*;

   // Configuration registers.
   logic [EPOCH_W-1:0] epoch_seconds_ff;
   logic               epoch_valid_ff;
   logic [SEQ_W-1:0]   start_sequence_ff;
   logic [SEQ_W-1:0]   max_sequence_ff;
   // Epoch in milliseconds, refreshed every cycle; it settles long before a request.
   logic [NOW_W-1:0]   epoch_ms_ff;

   // Sequencer state and the captured request.
   state_type          state_ff, state_in;
   logic               cmd_ff;
   logic [MODEL_W-1:0] model_ff;
   logic [NOW_W-1:0]   now_ff;
   logic [INST_W-1:0]  inst_ff;

   // Per-model memory: {last_instant, sequence_count}.
   logic [ENTRY_W-1:0]     ent_mem_ff [MODEL_COUNT];
   logic [MODEL_COUNT-1:0] vld_ff;
   logic [ENTRY_W-1:0]     rd_data_ff;
   logic                   rd_vld_ff;

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff;
   logic [PREFIX_W-1:0] rsp_prefix_ff;
   logic [TIME_W-1:0]  rsp_time_ff;

   // Handshake and control.
   logic               req_accept;
   logic               mem_re;
   logic               exec_fire;

   // Read-modify-write results.
   logic [SEQ_W-1:0]   cur_seq;
   logic [INST_W-1:0]  last_inst;
   logic               mem_we;
   logic [ENTRY_W-1:0] mem_wdata;
   status_type         status_calc;
   logic [PREFIX_W-1:0] prefix_calc;
   logic [TIME_W-1:0]  time_calc;

   assign req_accept = req_tvalid && req_tready;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_seconds_ff  <= '0;
         epoch_valid_ff    <= 1'b0;
         start_sequence_ff <= RESET_SEQUENCE;
         max_sequence_ff   <= RESET_MAX_SEQ;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_EPOCH_SECONDS:  epoch_seconds_ff  <= csr_wdata;
            CSR_EPOCH_VALID:    epoch_valid_ff    <= csr_wdata[0];
            CSR_START_SEQUENCE: start_sequence_ff <= csr_wdata[SEQ_W-1:0];
            CSR_MAX_SEQUENCE:   max_sequence_ff   <= csr_wdata[SEQ_W-1:0];
            default: ;
         endcase
      end
   end

   // Times 1000 as 1024 - 16 - 8, with shifts and two subtractions. The product of a
   // 37-bit value and 1000 stays below 2^47.
   always_ff @(posedge clock) begin
      epoch_ms_ff <= (NOW_W'(epoch_seconds_ff) << 10) - (NOW_W'(epoch_seconds_ff) << 4)
                     - (NOW_W'(epoch_seconds_ff) << 3);
   end

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_accept) state_in = ST_READ;
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: if (exec_fire) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Output logic of the sequencer. The execute step waits only while the response
   // register still holds a result that the sink has not taken.
   always_comb begin
      req_tready = 1'b0;
      exec_fire  = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_READ: ;
         ST_EXEC: exec_fire = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   assign mem_re = req_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Request capture and the instant, formed during the read-latency cycle. Both
   // operands stay below 2^47, so the 48-bit signed difference is exact.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff   <= req_tuser;
         model_ff <= req_tdata[MODEL_W-1:0];
         now_ff   <= req_tdata[MODEL_FIELD_W +: NOW_W];
      end
      if (state_ff == ST_READ) begin
         inst_ff <= {1'b0, now_ff} - {1'b0, epoch_ms_ff};
      end
   end

   // Memory with registered read. Requests are handled one at a time and the write
   // of one lands before the read of the next, so no forwarding is needed.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ent_mem_ff[model_ff] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= ent_mem_ff[req_tdata[MODEL_W-1:0]];
      end
   end

   // Entry valid flags stand in for the reset contents of the memory.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            vld_ff[model_ff] <= 1'b1;
         end
         if (mem_re) begin
            rd_vld_ff <= vld_ff[req_tdata[MODEL_W-1:0]];
         end
      end
   end

   assign cur_seq   = rd_vld_ff ? rd_data_ff[SEQ_W-1:0] : RESET_SEQUENCE;
   assign last_inst = rd_vld_ff ? rd_data_ff[SEQ_W +: INST_W] : '0;

   // Read-modify-write decision.
   always_comb begin
      status_calc = STATUS_OK;
      prefix_calc = '0;
      time_calc   = '0;
      mem_we      = 1'b0;
      mem_wdata   = {last_inst, cur_seq};
      if (cmd_ff == CMD_RESET) begin
         status_calc = STATUS_RESET_DONE;
         mem_we      = exec_fire;
         mem_wdata   = {last_inst, start_sequence_ff};
      end else if (!epoch_valid_ff) begin
         status_calc = STATUS_EPOCH_UNSET;
      end else if (cur_seq >= max_sequence_ff) begin
         // Exhausted counter: the error tells how the stored instant relates to now.
         if ($signed(last_inst) < $signed(inst_ff)) begin
            status_calc = STATUS_EPOCH_BAD;
         end else if (last_inst == inst_ff) begin
            status_calc = STATUS_OVERFLOW;
         end else begin
            status_calc = STATUS_NEED_RESET;
         end
      end else begin
         status_calc = STATUS_OK;
         prefix_calc = {sym('0), sym(DIGIT_W'(model_ff)), sym(cur_seq[17:12]),
                        sym(cur_seq[11:6]), sym(cur_seq[5:0])};
         for (int k = 0; k < TIME_CHARS; k++) begin
            time_calc[k*CHAR_W +: CHAR_W] = sym(inst_ff[k*DIGIT_W +: DIGIT_W]);
         end
         mem_we    = exec_fire;
         mem_wdata = {inst_ff, cur_seq + SEQ_W'(1)};
      end
   end

   // Response register; it parts the sink from the sequencer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_status_ff <= status_calc;
         rsp_prefix_ff <= prefix_calc;
         rsp_time_ff   <= time_calc;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_time_ff, rsp_prefix_ff};

`ifndef SYNTHESIS
   // An accepted request always moves the sequencer on to the read-latency step.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_READ)
      else $error("accepted request did not start a memory read");

   // A finished execute step always leaves a response waiting for the sink.
   assert property (@(posedge clock) disable iff (reset)
      exec_fire |=> rsp_tvalid)
      else $error("execute step produced no response");

   // The execute step stalls only behind an untaken response.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && !exec_fire) |-> (rsp_valid_ff && !rsp_tready))
      else $error("execute step stalled without back-pressure");

   // Only a successful generate carries identifier characters.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STATUS_OK) |-> rsp_tdata == '0)
      else $error("error or reset response carries identifier characters");
`endif

endmodule
